FILE: hw/rtl/dbea_pkg.sv
// Shared types, constants and the helper function of the bandwidth efficiency adjust unit.
package dbea_pkg;

    localparam int BW_BITS    = 40;
    localparam int PCT_W      = 7;
    localparam int DIG        = 8;
    localparam int DIV_STAGES = (BW_BITS + DIG - 1) / DIG;
    localparam int DIV_W      = DIV_STAGES * DIG;
    localparam int ADJ_W      = BW_BITS + PCT_W;
    localparam int TABLE_LEN  = 27;
    localparam int IDX_W      = 5;
    localparam int N_TABLES   = 6;
    localparam int TBL_W      = 3;
    localparam int MAXP_W     = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] KIND_DDR3   = 2'd0;
    localparam logic [1:0] KIND_LPDDR4 = 2'd1;
    localparam logic [1:0] KIND_LPDDR3 = 2'd2;
    localparam logic [1:0] KIND_DDR2   = 2'd3;

    localparam logic [3:0] FOUR_CH = 4'hf;
    localparam logic [3:0] TWO_CH  = 4'h3;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECC  = 2'd2;

    localparam logic [TBL_W-1:0] TBL_LP4_4CH_ECC = 3'd0;
    localparam logic [TBL_W-1:0] TBL_LP4_2CH_ECC = 3'd1;
    localparam logic [TBL_W-1:0] TBL_LP4_4CH     = 3'd2;
    localparam logic [TBL_W-1:0] TBL_LP4_2CH     = 3'd3;
    localparam logic [TBL_W-1:0] TBL_LPDDR3      = 3'd4;
    localparam logic [TBL_W-1:0] TBL_DDR3        = 3'd5;

    localparam logic [PCT_W-1:0] PCT_LP4     = 7'd70;
    localparam logic [PCT_W-1:0] PCT_OTHER   = 7'd80;
    localparam logic [PCT_W-1:0] PCT_HUNDRED = 7'd100;

    localparam logic [31:0] THR_HZ [TABLE_LEN] = '{
        32'd5000000,   32'd10000000,  32'd20000000,  32'd30000000,  32'd40000000,
        32'd60000000,  32'd80000000,  32'd100000000, 32'd120000000, 32'd140000000,
        32'd160000000, 32'd180000000, 32'd200000000, 32'd250000000, 32'd300000000,
        32'd350000000, 32'd360000000, 32'd370000000, 32'd380000000, 32'd400000000,
        32'd450000000, 32'd500000000, 32'd550000000, 32'd600000000, 32'd650000000,
        32'd700000000, 32'd750000000
    };

    localparam logic [5:0] ISO_PCT [N_TABLES][TABLE_LEN] = '{
        '{6'd15, 6'd15, 6'd15, 6'd15, 6'd15, 6'd15, 6'd15, 6'd15, 6'd15, 6'd15,
          6'd15, 6'd15, 6'd15, 6'd15, 6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,
          6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1},
        '{6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28,
          6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28, 6'd28,
          6'd28, 6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1},
        '{6'd15, 6'd19, 6'd27, 6'd35, 6'd40, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46,
          6'd48, 6'd49, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
          6'd50, 6'd50, 6'd50, 6'd50, 6'd48, 6'd46, 6'd45},
        '{6'd27, 6'd28, 6'd29, 6'd30, 6'd33, 6'd39, 6'd44, 6'd47, 6'd47, 6'd47,
          6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47,
          6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47},
        '{6'd31, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd44, 6'd48, 6'd48, 6'd48,
          6'd48, 6'd48, 6'd48, 6'd48, 6'd47, 6'd31, 6'd1,  6'd1,  6'd1,  6'd1,
          6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1},
        '{6'd28, 6'd29, 6'd32, 6'd34, 6'd36, 6'd41, 6'd45, 6'd47, 6'd47, 6'd47,
          6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47,
          6'd47, 6'd47, 6'd1,  6'd1,  6'd1,  6'd1,  6'd1}
    };

    // Last entry above one in each table.
    localparam logic [MAXP_W-1:0] MAX_PCT [N_TABLES] = '{
        6'd15, 6'd28, 6'd45, 6'd47, 6'd31, 6'd47
    };

    typedef struct packed {
        logic [BW_BITS-1:0] total;
        logic [BW_BITS-1:0] iso;
        logic [BW_BITS-1:0] ceiling;
        logic [PCT_W-1:0]   gen_pct;
        logic [PCT_W-1:0]   iso_pct;
        logic               over;
        logic               cfg_err;
        logic [MAXP_W-1:0]  maxp;
    } item_t;

    typedef struct packed {
        logic [PCT_W-1:0] rem;
        logic [DIV_W-1:0] work;
    } div_state_t;

    // One digit of restoring division; quotient bits shift in at the bottom.
    function automatic div_state_t div_step(div_state_t s, logic [PCT_W-1:0] d);
        div_state_t  o;
        logic [PCT_W:0] r;
        logic        ge;
        o = s;
        for (int k = 0; k < DIG; k++) begin
            r = {o.rem, o.work[DIV_W-1]};
            ge = (r >= {1'b0, d});
            o.work = {o.work[DIV_W-2:0], ge};
            o.rem = ge ? PCT_W'(r - {1'b0, d}) : PCT_W'(r);
        end
        return o;
    endfunction

endpackage

FILE: hw/rtl/dbea_classify.sv
// Front end: configuration registers and classification of each request.
module dbea_classify (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [dbea_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dbea_pkg::CFG_W-1:0]       cfg_data,
    input  logic [dbea_pkg::BW_BITS-1:0]     total,
    input  logic [dbea_pkg::BW_BITS-1:0]     iso,
    input  logic [dbea_pkg::BW_BITS-1:0]     ceiling,
    output dbea_pkg::item_t                  item
);

    logic [1:0] dram_reg;
    logic [3:0] chan_reg;
    logic       ecc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dram_reg <= dbea_pkg::KIND_LPDDR4;
            chan_reg <= dbea_pkg::FOUR_CH;
            ecc_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                dbea_pkg::CFG_DRAM: dram_reg <= cfg_data[1:0];
                dbea_pkg::CFG_CHAN: chan_reg <= cfg_data[3:0];
                dbea_pkg::CFG_ECC:  ecc_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [dbea_pkg::TBL_W-1:0]  tbl;
    logic [dbea_pkg::PCT_W-1:0]  gen;
    logic                        err;
    logic [dbea_pkg::IDX_W-1:0]  idx;
    logic [5:0]                  pct;

    always_comb begin
        tbl = dbea_pkg::TBL_DDR3;
        gen = dbea_pkg::PCT_OTHER;
        err = 1'b0;
        case (dram_reg)
            dbea_pkg::KIND_LPDDR4: begin
                gen = dbea_pkg::PCT_LP4;
                if (chan_reg == dbea_pkg::FOUR_CH) begin
                    tbl = ecc_reg ? dbea_pkg::TBL_LP4_4CH_ECC : dbea_pkg::TBL_LP4_4CH;
                end else if (chan_reg == dbea_pkg::TWO_CH) begin
                    tbl = ecc_reg ? dbea_pkg::TBL_LP4_2CH_ECC : dbea_pkg::TBL_LP4_2CH;
                end else begin
                    err = 1'b1;
                end
            end
            dbea_pkg::KIND_LPDDR3: tbl = dbea_pkg::TBL_LPDDR3;
            dbea_pkg::KIND_DDR3:   tbl = dbea_pkg::TBL_DDR3;
            default:               err = 1'b1;
        endcase
    end

    // Comparing in Hz against scaled thresholds matches the whole-MHz search.
    always_comb begin
        idx = '0;
        for (int i = 1; i < dbea_pkg::TABLE_LEN; i++) begin
            if (iso >= dbea_pkg::BW_BITS'(dbea_pkg::THR_HZ[i])) begin
                idx = dbea_pkg::IDX_W'(i);
            end
        end
        pct = dbea_pkg::ISO_PCT[tbl][idx];
    end

    always_comb begin
        item.total   = total;
        item.iso     = iso;
        item.ceiling = ceiling;
        item.gen_pct = gen;
        item.iso_pct = dbea_pkg::PCT_W'(pct);
        item.over    = (pct == 6'd1) && !err;
        item.cfg_err = err;
        item.maxp    = err ? '0 : dbea_pkg::MAX_PCT[tbl];
    end

endmodule

FILE: hw/rtl/dbea_queue.sv
// Two-entry queue between the front end and the divider back end.
module dbea_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  dbea_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_pop,
    output dbea_pkg::item_t rd_item
);

    dbea_pkg::item_t                  mem_reg [dbea_pkg::QUEUE_DEPTH];
    logic [dbea_pkg::QPTR_W-1:0]      wptr_reg;
    logic [dbea_pkg::QPTR_W-1:0]      rptr_reg;
    logic [dbea_pkg::QCNT_W-1:0]      cnt_reg;
    logic                             push;
    logic                             pop;

    assign wr_ready = cnt_reg < dbea_pkg::QCNT_W'(dbea_pkg::QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_item  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + dbea_pkg::QCNT_W'(push) - dbea_pkg::QCNT_W'(pop);
        end
    end

endmodule

FILE: hw/rtl/dbea_divider.sv
// Pipelined restoring divider by a small divisor, one digit per stage.
module dbea_divider (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [dbea_pkg::BW_BITS-1:0]  dividend,
    input  logic [dbea_pkg::PCT_W-1:0]    divisor,
    output logic [dbea_pkg::DIV_W-1:0]    quotient
);

    dbea_pkg::div_state_t        st_reg [dbea_pkg::DIV_STAGES];
    logic [dbea_pkg::PCT_W-1:0]  d_reg  [dbea_pkg::DIV_STAGES];
    dbea_pkg::div_state_t        first;

    always_comb begin
        first.rem  = '0;
        first.work = dbea_pkg::DIV_W'(dividend);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= dbea_pkg::div_step(first, divisor);
            d_reg[0]  <= divisor;
            for (int s = 1; s < dbea_pkg::DIV_STAGES; s++) begin
                st_reg[s] <= dbea_pkg::div_step(st_reg[s-1], d_reg[s-1]);
                d_reg[s]  <= d_reg[s-1];
            end
        end
    end

    assign quotient = st_reg[dbea_pkg::DIV_STAGES-1].work;

endmodule

FILE: hw/rtl/dbea_execute.sv
// Back end: divides by the efficiencies, applies the ceiling and holds the result.
module dbea_execute (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  dbea_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dbea_pkg::BW_BITS-1:0]  m_required_bw,
    output logic [dbea_pkg::BW_BITS-1:0]  m_iso_adjusted,
    output logic                          m_iso_over_limit,
    output logic                          m_config_error,
    output logic [dbea_pkg::MAXP_W-1:0]   m_max_iso_percent
);

    typedef struct packed {
        logic [dbea_pkg::BW_BITS-1:0] ceiling;
        logic                         ztot;
        logic                         ziso;
        logic                         over;
        logic                         cfg_err;
        logic [dbea_pkg::MAXP_W-1:0]  maxp;
    } side_t;

    logic                          adv;
    logic [dbea_pkg::DIV_STAGES-1:0] v_reg;
    side_t                         side_reg [dbea_pkg::DIV_STAGES];
    side_t                         side_in;
    logic [dbea_pkg::DIV_W-1:0]    q_tot;
    logic [dbea_pkg::DIV_W-1:0]    q_iso;
    logic [dbea_pkg::DIV_W-1:0]    q_cdiv;
    logic                          a_valid_reg;
    side_t                         a_side_reg;
    logic [dbea_pkg::ADJ_W-1:0]    a_tot_reg;
    logic [dbea_pkg::ADJ_W-1:0]    a_iso_reg;
    logic [dbea_pkg::ADJ_W-1:0]    tot_next;
    logic [dbea_pkg::ADJ_W-1:0]    iso_next;
    logic [dbea_pkg::ADJ_W-1:0]    req_full;
    logic                          m_valid_reg;
    side_t                         last;

    // The whole back end moves together unless a finished result is stuck.
    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    always_comb begin
        side_in.ceiling = q_item.ceiling;
        side_in.ztot    = q_item.total == '0;
        side_in.ziso    = q_item.iso == '0;
        side_in.over    = q_item.over;
        side_in.cfg_err = q_item.cfg_err;
        side_in.maxp    = q_item.maxp;
    end

    dbea_divider u_div_tot (
        .aclk(aclk), .en(adv), .dividend(q_item.total),
        .divisor(q_item.gen_pct), .quotient(q_tot)
    );
    dbea_divider u_div_iso (
        .aclk(aclk), .en(adv), .dividend(q_item.iso),
        .divisor(q_item.iso_pct), .quotient(q_iso)
    );
    dbea_divider u_div_ceil (
        .aclk(aclk), .en(adv), .dividend(q_item.ceiling),
        .divisor(dbea_pkg::PCT_HUNDRED), .quotient(q_cdiv)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v_reg       <= {v_reg[dbea_pkg::DIV_STAGES-2:0], q_valid};
            a_valid_reg <= v_reg[dbea_pkg::DIV_STAGES-1];
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_in;
            for (int s = 1; s < dbea_pkg::DIV_STAGES; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign last = side_reg[dbea_pkg::DIV_STAGES-1];

    // A zero request stays zero; otherwise the scaled quotient or the ceiling.
    always_comb begin
        if (last.ztot) begin
            tot_next = '0;
        end else if (q_tot < q_cdiv) begin
            tot_next = dbea_pkg::ADJ_W'(q_tot) * dbea_pkg::ADJ_W'(dbea_pkg::PCT_HUNDRED);
        end else begin
            tot_next = dbea_pkg::ADJ_W'(last.ceiling);
        end
        if (last.ziso) begin
            iso_next = '0;
        end else if (q_iso < q_cdiv) begin
            iso_next = dbea_pkg::ADJ_W'(q_iso) * dbea_pkg::ADJ_W'(dbea_pkg::PCT_HUNDRED);
        end else begin
            iso_next = dbea_pkg::ADJ_W'(last.ceiling);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_side_reg <= last;
            a_tot_reg  <= tot_next;
            a_iso_reg  <= iso_next;
        end
    end

    assign req_full = (a_tot_reg > a_iso_reg) ? a_tot_reg : a_iso_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_required_bw     <= a_side_reg.cfg_err ? '0 : req_full[dbea_pkg::BW_BITS-1:0];
            m_iso_adjusted    <= a_side_reg.cfg_err ? '0 : a_iso_reg[dbea_pkg::BW_BITS-1:0];
            m_iso_over_limit  <= a_side_reg.over;
            m_config_error    <= a_side_reg.cfg_err;
            m_max_iso_percent <= a_side_reg.maxp;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: hw/rtl/dram_bandwidth_efficiency_adjust_unit.sv
// Top level of the DRAM bandwidth efficiency adjust unit.
// Accepts one request per cycle while s_ready is high; one result each, in order.
// After acceptance a request passes through the queue, the DIV_STAGES divider
// stages, which retire eight quotient bits each, then the ceiling/scale stage and
// the output register. A stalled result freezes the whole back end; the two-entry
// queue then fills and the input stalls. The queue separates the classifying front
// end from the divider back end.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
module dram_bandwidth_efficiency_adjust_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dbea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbea_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dbea_pkg::BW_BITS-1:0]    s_total_request,
    input  logic [dbea_pkg::BW_BITS-1:0]    s_iso_request,
    input  logic [dbea_pkg::BW_BITS-1:0]    s_rate_ceiling,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dbea_pkg::BW_BITS-1:0]    m_required_bw,
    output logic [dbea_pkg::BW_BITS-1:0]    m_iso_adjusted,
    output logic                            m_iso_over_limit,
    output logic                            m_config_error,
    output logic [dbea_pkg::MAXP_W-1:0]     m_max_iso_percent
);

    dbea_pkg::item_t front_item;
    dbea_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;

    dbea_classify u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .total(s_total_request), .iso(s_iso_request), .ceiling(s_rate_ceiling),
        .item(front_item)
    );

    dbea_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_item(front_item),
        .rd_valid(q_valid), .rd_pop(q_pop), .rd_item(q_item)
    );

    dbea_execute u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_required_bw(m_required_bw), .m_iso_adjusted(m_iso_adjusted),
        .m_iso_over_limit(m_iso_over_limit), .m_config_error(m_config_error),
        .m_max_iso_percent(m_max_iso_percent)
    );

endmodule

FILE: hw/rtl/dbea_checker.sv
// Port-level checks of the adjust unit, bound to the top level.
module dbea_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [dbea_pkg::BW_BITS-1:0]    m_required_bw,
    input logic [dbea_pkg::BW_BITS-1:0]    m_iso_adjusted,
    input logic                            m_iso_over_limit,
    input logic                            m_config_error,
    input logic [dbea_pkg::MAXP_W-1:0]     m_max_iso_percent
);

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_config_error |->
            m_required_bw == '0 && m_iso_adjusted == '0 &&
            !m_iso_over_limit && m_max_iso_percent == '0)
        else $error("config error result carries nonzero fields");

    a_err_pct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_config_error |-> m_max_iso_percent != '0)
        else $error("supported configuration reported no maximum percent");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_required_bw))
        else $error("stalled result changed");

endmodule

bind dram_bandwidth_efficiency_adjust_unit dbea_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_required_bw(m_required_bw), .m_iso_adjusted(m_iso_adjusted),
    .m_iso_over_limit(m_iso_over_limit), .m_config_error(m_config_error),
    .m_max_iso_percent(m_max_iso_percent)
);

FILE: test/tb.sv
// Self-checking testbench of the DRAM bandwidth efficiency adjust unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = dbea_pkg::DIV_STAGES + 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [dbea_pkg::BW_BITS-1:0] BW_MAX = {dbea_pkg::BW_BITS{1'b1}};

    typedef struct packed {
        logic [dbea_pkg::BW_BITS-1:0] total;
        logic [dbea_pkg::BW_BITS-1:0] iso;
        logic [dbea_pkg::BW_BITS-1:0] ceiling;
    } request_t;

    typedef struct packed {
        logic [dbea_pkg::BW_BITS-1:0] required;
        logic [dbea_pkg::BW_BITS-1:0] iso_adj;
        logic                         over;
        logic                         cfg_err;
        logic [dbea_pkg::MAXP_W-1:0]  maxp;
    } grant_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [dbea_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dbea_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [dbea_pkg::BW_BITS-1:0]   s_total_request = '0;
    logic [dbea_pkg::BW_BITS-1:0]   s_iso_request = '0;
    logic [dbea_pkg::BW_BITS-1:0]   s_rate_ceiling = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [dbea_pkg::BW_BITS-1:0]   m_required_bw;
    logic [dbea_pkg::BW_BITS-1:0]   m_iso_adjusted;
    logic                           m_iso_over_limit;
    logic                           m_config_error;
    logic [dbea_pkg::MAXP_W-1:0]    m_max_iso_percent;

    dram_bandwidth_efficiency_adjust_unit uut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    logic [1:0] dram_sh = dbea_pkg::KIND_LPDDR4;
    logic [3:0] chan_sh = dbea_pkg::FOUR_CH;
    logic       ecc_sh  = 1'b0;

    request_t pending_requests[$];
    grant_t   expected_grants[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_off = 0;
    int       mismatches = 0;
    int       cycles = 0;
    logic     in_taken = 1'b0;

    function automatic logic [dbea_pkg::BW_BITS-1:0] scale_bw(
        logic [dbea_pkg::BW_BITS-1:0] bw, int pct, logic [dbea_pkg::BW_BITS-1:0] ceil_v);
        logic [dbea_pkg::BW_BITS-1:0] q;
        if (bw == 0 || pct == 0 || pct >= 100) return bw;
        q = bw / pct;
        return (q < ceil_v / 100) ? dbea_pkg::BW_BITS'(q * 100) : ceil_v;
    endfunction

    function automatic grant_t predict_grant(request_t r);
        grant_t                       g;
        logic                         ok;
        logic [dbea_pkg::TBL_W-1:0]   tbl;
        logic [dbea_pkg::PCT_W-1:0]   gen;
        int                           idx;
        logic [dbea_pkg::BW_BITS-1:0] mhz, at, ai;
        g = '0;
        ok = 1'b1;
        tbl = dbea_pkg::TBL_DDR3;
        gen = dbea_pkg::PCT_OTHER;
        case (dram_sh)
            dbea_pkg::KIND_LPDDR4: begin
                gen = dbea_pkg::PCT_LP4;
                if (chan_sh == dbea_pkg::FOUR_CH) begin
                    tbl = ecc_sh ? dbea_pkg::TBL_LP4_4CH_ECC : dbea_pkg::TBL_LP4_4CH;
                end else if (chan_sh == dbea_pkg::TWO_CH) begin
                    tbl = ecc_sh ? dbea_pkg::TBL_LP4_2CH_ECC : dbea_pkg::TBL_LP4_2CH;
                end else begin
                    ok = 1'b0;
                end
            end
            dbea_pkg::KIND_LPDDR3: tbl = dbea_pkg::TBL_LPDDR3;
            dbea_pkg::KIND_DDR3:   tbl = dbea_pkg::TBL_DDR3;
            default:               ok = 1'b0;
        endcase
        if (!ok) begin
            g.cfg_err = 1'b1;
            return g;
        end
        mhz = r.iso / 1000000;
        idx = dbea_pkg::TABLE_LEN - 1;
        while (idx > 0 && dbea_pkg::THR_HZ[idx] / 1000000 > mhz) idx--;
        at = scale_bw(r.total, int'(gen), r.ceiling);
        ai = scale_bw(r.iso, int'(dbea_pkg::ISO_PCT[tbl][idx]), r.ceiling);
        for (int i = dbea_pkg::TABLE_LEN - 1; i >= 0; i--) begin
            if (dbea_pkg::ISO_PCT[tbl][i] > 1) begin
                g.maxp = dbea_pkg::ISO_PCT[tbl][i];
                break;
            end
        end
        g.required = (at > ai) ? at : ai;
        g.iso_adj = ai;
        g.over = (dbea_pkg::ISO_PCT[tbl][idx] == 1);
        return g;
    endfunction

    // Input acceptance is captured at the rising edge where it happens.
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
    end

    // Long receiver hold-off, counted down on its own.
    always @(negedge aclk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // Driver: the predictor runs at acceptance, so it sees the live configuration.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                expected_grants.push_back(predict_grant(
                    '{s_total_request, s_iso_request, s_rate_ceiling}));
                void'(pending_requests.pop_front());
            end
            if (!s_valid || in_taken) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_total_request <= pending_requests[0].total;
                    s_iso_request <= pending_requests[0].iso;
                    s_rate_ceiling <= pending_requests[0].ceiling;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (hold_off > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        grant_t got, exp_g;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_required_bw, m_iso_adjusted, m_iso_over_limit, m_config_error,
                    m_max_iso_percent};
            if (expected_grants.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result item %p", got);
            end else begin
                exp_g = expected_grants.pop_front();
                if (got !== exp_g) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("mismatch: expected %p got %p", exp_g, got);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [dbea_pkg::CFG_IDX_W-1:0] idx,
                             logic [dbea_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            dbea_pkg::CFG_DRAM: dram_sh = val[1:0];
            dbea_pkg::CFG_CHAN: chan_sh = val;
            dbea_pkg::CFG_ECC:  ecc_sh  = val[0];
            default: ;
        endcase
    endtask

    task automatic drain_all();
        while (pending_requests.size() > 0 || s_valid || expected_grants.size() > 0)
            @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    function automatic logic [dbea_pkg::BW_BITS-1:0] rand_bw();
        return dbea_pkg::BW_BITS'({$urandom, $urandom});
    endfunction

    function automatic logic [dbea_pkg::BW_BITS-1:0] rand_iso();
        case ($urandom_range(3))
            0: return rand_bw();
            1: return dbea_pkg::BW_BITS'($urandom_range(800000000));
            2: return dbea_pkg::BW_BITS'(dbea_pkg::THR_HZ[$urandom_range(dbea_pkg::TABLE_LEN - 1)])
                      - dbea_pkg::BW_BITS'($urandom_range(1));
            default: return dbea_pkg::BW_BITS'($urandom_range(9000000));
        endcase
    endfunction

    function automatic logic [dbea_pkg::BW_BITS-1:0] rand_ceiling();
        case ($urandom_range(3))
            0: return rand_bw();
            1: return dbea_pkg::BW_BITS'($urandom_range(150));
            default: return dbea_pkg::BW_BITS'({$urandom_range(255), $urandom});
        endcase
    endfunction

    task automatic queue_random(int n);
        logic [dbea_pkg::BW_BITS-1:0] t;
        for (int i = 0; i < n; i++) begin
            t = ($urandom_range(9) == 0) ? '0 : rand_bw();
            if ($urandom_range(1)) t = t >> $urandom_range(30);
            pending_requests.push_back('{t, ($urandom_range(12) == 0) ? '0 : rand_iso(),
                                         rand_ceiling()});
        end
    endtask

    initial begin
        logic [dbea_pkg::CFG_W-1:0] chans [4] = '{dbea_pkg::FOUR_CH, dbea_pkg::TWO_CH,
                                                  4'h0, 4'h5};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed part, first at the reset configuration, then at others.
        pending_requests.push_back('{'0, '0, BW_MAX});
        pending_requests.push_back('{BW_MAX, BW_MAX, BW_MAX});
        pending_requests.push_back('{BW_MAX, 40'd4999999, BW_MAX});
        pending_requests.push_back('{40'd1000, 40'd5000000, BW_MAX});
        pending_requests.push_back('{40'd123456789, 40'd750000000, BW_MAX});
        pending_requests.push_back('{40'd123456789, 40'd749999999, 40'd99});
        pending_requests.push_back('{40'd5, 40'd300000000, 40'd0});
        pending_requests.push_back('{40'h5555555555, 40'haaaaaaaaaa, 40'd100});
        pending_requests.push_back('{40'haaaaaaaaaa, 40'h5555555555, 40'd10000});
        drain_all();
        write_reg(dbea_pkg::CFG_ECC, 4'h1);
        pending_requests.push_back('{40'd700, 40'd350000000, BW_MAX});
        pending_requests.push_back('{40'd700, 40'd349999999, BW_MAX});
        drain_all();
        write_reg(dbea_pkg::CFG_DRAM, dbea_pkg::CFG_W'(dbea_pkg::KIND_DDR2));
        pending_requests.push_back('{BW_MAX, BW_MAX, BW_MAX});
        drain_all();
        write_reg(dbea_pkg::CFG_DRAM, dbea_pkg::CFG_W'(dbea_pkg::KIND_LPDDR4));
        write_reg(dbea_pkg::CFG_CHAN, 4'h7);
        pending_requests.push_back('{40'd100, 40'd100, BW_MAX});
        drain_all();

        // Random phases cycling through configurations and idling profiles.
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(dbea_pkg::CFG_DRAM, dbea_pkg::CFG_W'($urandom_range(3)));
            write_reg(dbea_pkg::CFG_CHAN, ($urandom_range(3) == 0) ?
                      dbea_pkg::CFG_W'($urandom) : chans[ph % 2]);
            write_reg(dbea_pkg::CFG_ECC, dbea_pkg::CFG_W'($urandom_range(1)));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (ph == 4) hold_off = 200;
            queue_random(27);
            drain_all();
        end
        write_reg(dbea_pkg::CFG_DRAM, dbea_pkg::CFG_W'(dbea_pkg::KIND_LPDDR4));
        write_reg(dbea_pkg::CFG_CHAN, chans[2]);
        queue_random(3);
        drain_all();
        if (mismatches == 0 && expected_grants.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/dbea_pkg.sv
hw/rtl/dbea_classify.sv
hw/rtl/dbea_queue.sv
hw/rtl/dbea_divider.sv
hw/rtl/dbea_execute.sv
hw/rtl/dram_bandwidth_efficiency_adjust_unit.sv
hw/rtl/dbea_checker.sv
test/tb.sv
